@@ src/bce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block colour entropy package
// Shared sizes, types and helper functions for the colour entropy core and
// its divider.
// ----------------------------------------------------------------------------
package bce_pkg;

   // Largest number of pixels counted in one block.
   localparam int MaxPixels = 256;

   // Width of a pixel count that can hold MaxPixels itself.
   localparam int CntW = $clog2(MaxPixels + 1);
   // Index into the list of touched bins.
   localparam int IdxW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;
   // Width of floor(log2) of a count.
   localparam int LogW = (CntW > 1) ? $clog2(CntW) : 1;
   // Width of the weighted sum over all bins.
   localparam int SumW = CntW + LogW;
   // Scaling of the score, and the width of the scaled sum.
   localparam int ScaleFactor = 100;
   localparam int ProdW = SumW + 7;
   // Iteration counter of the divider.
   localparam int DivCntW = $clog2(ProdW + 1);

   // Quantised 5-6-5 colour.
   localparam int ColorW = 16;
   localparam int ColorBins = 65536;
   localparam logic [7:0] RedMask = 8'hF8;
   localparam logic [7:0] GreenMask = 8'hFC;

   // Widths of the result fields.
   localparam int ScoreW = 10;
   localparam int PixelsW = 9;

   typedef logic [CntW-1:0] count_type;
   typedef logic [LogW-1:0] log_type;
   typedef logic [ColorW-1:0] color_type;

   // Reduce an RGB pixel to its 5-6-5 colour code.
   function automatic color_type quantize(logic [7:0] red, logic [7:0] green,
                                          logic [7:0] blue);
      logic [7:0] r_m;
      logic [7:0] g_m;
      r_m = red & RedMask;
      g_m = green & GreenMask;
      return {r_m[7:3], g_m[7:2], blue[7:3]};
   endfunction

   // Position of the highest set bit; zero for an input of zero or one.
   function automatic log_type floor_log2(count_type v);
      log_type r;
      r = '0;
      for (int i = 1; i < CntW; i++) begin
         if (v[i]) begin
            r = LogW'(i);
         end
      end
      return r;
   endfunction

endpackage

@@ src/bce_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block colour entropy divider
// Restoring divider that produces one quotient bit per cycle. The quotient
// holds its value from the done pulse until the next start.
// ----------------------------------------------------------------------------
module bce_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bce_pkg::ProdW-1:0]   dividend,
   input  bce_pkg::count_type          divisor,
   output logic                        done,
   output logic [bce_pkg::ProdW-1:0]   quotient
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [bce_pkg::DivCntW-1:0] step_ff, step_in;
   bce_pkg::count_type          rem_ff, rem_in;
   logic [bce_pkg::ProdW-1:0]   quo_ff, quo_in;
   logic [bce_pkg::CntW:0]      shifted;
   logic [bce_pkg::CntW:0]      trial;
   logic                        fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[bce_pkg::ProdW-1]};
      trial = shifted - {1'b0, divisor};
      fits = (shifted >= {1'b0, divisor});
   end

   // Next-state logic of the iteration.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial[bce_pkg::CntW-1:0] : shifted[bce_pkg::CntW-1:0];
         quo_in = {quo_ff[bce_pkg::ProdW-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == bce_pkg::DivCntW'(bce_pkg::ProdW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/block_color_entropy_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block colour entropy core
// Histograms the 5-6-5 colours of an image block and, on the last pixel,
// reports an integer entropy score: 100 * sum(count * (log2 N - log2 count))
// divided by the pixel total N.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  red, green, blue, last_pixel
//   rsp_      out        rsp_valid/rsp_stall  entropy_score, block_pixels,
//                                             overflow_flag
//
// A pixel takes one read of the histogram memory and one write back.
// A last pixel adds a walk over the touched list and the histogram, a scaling
// step, the divider's restoring iterations and a load of the result register.
// After reset a clearing pass writes each of the 65536 histogram entries once,
// and req_stall is high during it.
// A finished result waits in its own register; the next block's pixels are
// taken meanwhile, and only the next result waits for rsp_stall to fall.
//
module block_color_entropy_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   input  logic                         req_last_pixel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bce_pkg::ScoreW-1:0]   rsp_entropy_score,
   output logic [bce_pkg::PixelsW-1:0]  rsp_block_pixels,
   output logic                         rsp_overflow_flag
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_WALK,
      ST_SCALE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Control and datapath registers.
   state_type                       state_ff, state_in;
   bce_pkg::color_type              clear_idx_ff, clear_idx_in;
   bce_pkg::color_type              color_ff, color_in;
   logic                            last_ff, last_in;
   logic                            count_ff, count_in;
   bce_pkg::count_type              pixel_total_ff, pixel_total_in;
   bce_pkg::count_type              touched_total_ff, touched_total_in;
   logic                            overflow_ff, overflow_in;
   bce_pkg::count_type              issue_idx_ff, issue_idx_in;
   logic                            t_vld_ff, t_vld_in;
   logic                            c_vld_ff, c_vld_in;
   bce_pkg::color_type              walk_bin_ff, walk_bin_in;
   bce_pkg::log_type                log_n_ff, log_n_in;
   logic [bce_pkg::SumW-1:0]        sum_ff, sum_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bce_pkg::ScoreW-1:0]      rsp_score_ff, rsp_score_in;
   logic [bce_pkg::PixelsW-1:0]     rsp_pixels_ff, rsp_pixels_in;
   logic                            rsp_overflow_ff, rsp_overflow_in;

   // Histogram memory: one read port, one write port.
   bce_pkg::count_type              bin_mem [bce_pkg::ColorBins];
   logic                            bin_rd_en;
   bce_pkg::color_type              bin_rd_addr;
   bce_pkg::count_type              bin_rd_data_ff;
   logic                            bin_wr_en;
   bce_pkg::color_type              bin_wr_addr;
   bce_pkg::count_type              bin_wr_data;

   // List of bins first touched in this block.
   bce_pkg::color_type              touched_mem [bce_pkg::MaxPixels];
   logic                            touched_rd_en;
   logic [bce_pkg::IdxW-1:0]        touched_rd_addr;
   bce_pkg::color_type              touched_rd_data_ff;
   logic                            touched_wr_en;
   logic [bce_pkg::IdxW-1:0]        touched_wr_addr;

   // Divider connection.
   logic                            div_start;
   logic [bce_pkg::ProdW-1:0]       div_dividend;
   logic                            div_done;
   logic [bce_pkg::ProdW-1:0]       div_quotient;
   logic [31:0]                     quo_wide;
   logic [31:0]                     pix_wide;

   // Helpers.
   logic                            req_fire;
   logic                            counting;
   logic                            issue;
   logic                            out_free;
   bce_pkg::log_type                cnt_log;
   bce_pkg::log_type                log_diff;
   logic [bce_pkg::SumW-1:0]        term;

   assign req_fire = req_valid && (state_ff == ST_IDLE);
   assign counting = (pixel_total_ff < bce_pkg::CntW'(bce_pkg::MaxPixels));
   assign issue = (state_ff == ST_WALK) && (issue_idx_ff < touched_total_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Contribution of the bin whose count has just been read during the walk.
   always_comb begin
      cnt_log = bce_pkg::floor_log2(bin_rd_data_ff);
      log_diff = log_n_ff - cnt_log;
      if ((bin_rd_data_ff != '0) && (cnt_log <= log_n_ff)) begin
         term = bce_pkg::SumW'(bin_rd_data_ff) * bce_pkg::SumW'(log_diff);
      end else begin
         term = '0;
      end
   end

   // Memory port steering.
   always_comb begin
      bin_rd_en = 1'b0;
      bin_rd_addr = bce_pkg::quantize(req_red, req_green, req_blue);
      bin_wr_en = 1'b0;
      bin_wr_addr = color_ff;
      bin_wr_data = bin_rd_data_ff + 1'b1;
      touched_rd_en = issue;
      touched_rd_addr = issue_idx_ff[bce_pkg::IdxW-1:0];
      touched_wr_en = 1'b0;
      touched_wr_addr = touched_total_ff[bce_pkg::IdxW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            bin_wr_en = 1'b1;
            bin_wr_addr = clear_idx_ff;
            bin_wr_data = '0;
         end
         ST_IDLE: begin
            bin_rd_en = req_fire && counting;
         end
         ST_UPDATE: begin
            bin_wr_en = count_ff;
            touched_wr_en = count_ff && (bin_rd_data_ff == '0) &&
                            (touched_total_ff < bce_pkg::CntW'(bce_pkg::MaxPixels));
         end
         ST_WALK: begin
            bin_rd_en = t_vld_ff;
            bin_rd_addr = touched_rd_data_ff;
            bin_wr_en = c_vld_ff;
            bin_wr_addr = walk_bin_ff;
            bin_wr_data = '0;
         end
         ST_SCALE, ST_DIVIDE, ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Histogram memory.
   always_ff @(posedge clock) begin
      if (bin_wr_en) begin
         bin_mem[bin_wr_addr] <= bin_wr_data;
      end
      if (bin_rd_en) begin
         bin_rd_data_ff <= bin_mem[bin_rd_addr];
      end
   end

   // Touched-bin list memory.
   always_ff @(posedge clock) begin
      if (touched_wr_en) begin
         touched_mem[touched_wr_addr] <= color_ff;
      end
      if (touched_rd_en) begin
         touched_rd_data_ff <= touched_mem[touched_rd_addr];
      end
   end

   // The scaled sum goes straight into the divider, which registers it.
   assign div_start = (state_ff == ST_SCALE);
   assign div_dividend = bce_pkg::ProdW'(sum_ff) *
                         bce_pkg::ProdW'(bce_pkg::ScaleFactor);

   bce_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (pixel_total_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign quo_wide = 32'(div_quotient);
   assign pix_wide = 32'(pixel_total_ff);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      clear_idx_in = clear_idx_ff;
      color_in = color_ff;
      last_in = last_ff;
      count_in = count_ff;
      pixel_total_in = pixel_total_ff;
      touched_total_in = touched_total_ff;
      overflow_in = overflow_ff;
      issue_idx_in = issue_idx_ff;
      t_vld_in = 1'b0;
      c_vld_in = 1'b0;
      walk_bin_in = walk_bin_ff;
      log_n_in = log_n_ff;
      sum_in = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_score_in = rsp_score_ff;
      rsp_pixels_in = rsp_pixels_ff;
      rsp_overflow_in = rsp_overflow_ff;

      unique case (state_ff)
         // Sweep the histogram to zero once after reset.
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         // Take a pixel; its bin count is read at this edge.
         ST_IDLE: begin
            if (req_fire) begin
               color_in = bce_pkg::quantize(req_red, req_green, req_blue);
               last_in = req_last_pixel;
               count_in = counting;
               if (!counting) begin
                  overflow_in = 1'b1;
               end
               state_in = ST_UPDATE;
            end
         end

         // Write back the incremented count and note a first touch.
         ST_UPDATE: begin
            if (count_ff) begin
               pixel_total_in = pixel_total_ff + 1'b1;
               if (touched_wr_en) begin
                  touched_total_in = touched_total_ff + 1'b1;
               end
            end
            if (last_ff) begin
               log_n_in = bce_pkg::floor_log2(pixel_total_in);
               issue_idx_in = '0;
               sum_in = '0;
               state_in = ST_WALK;
            end else begin
               state_in = ST_IDLE;
            end
         end

         // Three-step walk: list read, count read, accumulate and clear.
         ST_WALK: begin
            if (issue) begin
               issue_idx_in = issue_idx_ff + 1'b1;
            end
            t_vld_in = issue;
            c_vld_in = t_vld_ff;
            walk_bin_in = touched_rd_data_ff;
            if (c_vld_ff) begin
               sum_in = sum_ff + term;
            end
            if (!issue && !t_vld_ff && !c_vld_ff) begin
               state_in = ST_SCALE;
            end
         end

         ST_SCALE: begin
            state_in = ST_DIVIDE;
         end

         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end

         // Hand over the result and start a fresh block.
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = (pixel_total_ff == '0) ? '0 :
                              quo_wide[bce_pkg::ScoreW-1:0];
               rsp_pixels_in = pix_wide[bce_pkg::PixelsW-1:0];
               rsp_overflow_in = overflow_ff;
               pixel_total_in = '0;
               touched_total_in = '0;
               overflow_in = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_idx_ff <= '0;
         pixel_total_ff <= '0;
         touched_total_ff <= '0;
         overflow_ff <= 1'b0;
         t_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_idx_ff <= clear_idx_in;
         pixel_total_ff <= pixel_total_in;
         touched_total_ff <= touched_total_in;
         overflow_ff <= overflow_in;
         t_vld_ff <= t_vld_in;
         c_vld_ff <= c_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      color_ff <= color_in;
      last_ff <= last_in;
      count_ff <= count_in;
      issue_idx_ff <= issue_idx_in;
      walk_bin_ff <= walk_bin_in;
      log_n_ff <= log_n_in;
      sum_ff <= sum_in;
      rsp_score_ff <= rsp_score_in;
      rsp_pixels_ff <= rsp_pixels_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_entropy_score = rsp_score_ff;
   assign rsp_block_pixels = rsp_pixels_ff;
   assign rsp_overflow_flag = rsp_overflow_ff;

`ifndef SYNTH
   // The touched list never outgrows the pixel count, which stays in range.
   a_totals: assert property (@(posedge clock) disable iff (reset)
      (touched_total_ff <= pixel_total_ff) &&
      (pixel_total_ff <= bce_pkg::CntW'(bce_pkg::MaxPixels)))
      else $error("touched or pixel total out of range");

   // A counted pixel never finds a bin already at the pixel limit.
   a_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && count_ff) |->
      (bin_rd_data_ff < bce_pkg::CntW'(bce_pkg::MaxPixels)))
      else $error("bin count would wrap");

   // The divider is only started with a non-zero pixel total.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> (pixel_total_ff != '0))
      else $error("division by a zero pixel total");

   // A new result appears only from the finishing step.
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finishing step");
`endif

endmodule
